[hw/rtl/ucds_pkg.sv]
// Package for the USB configuration descriptor scanner: token and opcode types,
// descriptor codes and register indexes. It depends on nothing else.
package ucds_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;

  localparam logic [7:0] OFS_LENGTH    = 8'd0;
  localparam logic [7:0] OFS_TYPE      = 8'd1;
  localparam logic [7:0] OFS_IF_NUM    = 8'd2;
  localparam logic [7:0] OFS_IF_CLASS  = 8'd5;
  localparam logic [7:0] OFS_IF_SUB    = 8'd6;
  localparam logic [7:0] OFS_IF_PROTO  = 8'd7;
  localparam logic [7:0] OFS_EP_ADDR   = 8'd2;
  localparam logic [7:0] OFS_EP_ATTR   = 8'd3;
  localparam logic [7:0] OFS_EP_MPS_LO = 8'd4;
  localparam logic [7:0] OFS_EP_MPS_HI = 8'd5;

  localparam logic [1:0] XFER_INTERRUPT = 2'b11;
  localparam int unsigned EpDirBit      = 7;

  localparam logic [1:0] REG_CLASS    = 2'd0;
  localparam logic [1:0] REG_SUBCLASS = 2'd1;
  localparam logic [1:0] REG_PROTOCOL = 2'd2;

  localparam logic [7:0] CLASS_RESET    = 8'd3;
  localparam logic [7:0] SUBCLASS_RESET = 8'd1;
  localparam logic [7:0] PROTOCOL_RESET = 8'd1;

  typedef enum logic [1:0] {
    PROG_NONE  = 2'd0,
    PROG_CLASS = 2'd1,
    PROG_SUB   = 2'd2
  } prog_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ZERO_LEN,
    OP_IF_NUM,
    OP_IF_CLASS,
    OP_IF_SUB,
    OP_IF_PROTO,
    OP_EP_ADDR,
    OP_EP_ATTR,
    OP_EP_MPS_LO,
    OP_EP_MPS_HI
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       last;
  } token_t;

endpackage

[hw/rtl/ucds_front.sv]
// Front end of the scanner: walks descriptors by their length bytes and turns
// each accepted byte into a classified token. Depends on ucds_pkg.
module ucds_front import ucds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output token_t     tok
);

  logic [7:0] byte_offset, byte_offset_next;
  logic [7:0] desc_length, desc_length_next;
  logic [7:0] desc_type, desc_type_next;
  logic       halted, halted_next;
  logic [8:0] offset_inc;

  always_comb begin
    tok.op   = OP_NONE;
    tok.data = data_byte;
    tok.last = last_byte;
    byte_offset_next = byte_offset;
    desc_length_next = desc_length;
    desc_type_next   = desc_type;
    halted_next      = halted;
    offset_inc       = {1'b0, byte_offset} + 9'd1;

    if (!halted) begin
      if (byte_offset == OFS_LENGTH) begin
        if (data_byte == 8'd0) begin
          tok.op = OP_ZERO_LEN;
          halted_next = 1'b1;
        end else begin
          desc_length_next = data_byte;
          desc_type_next   = 8'd0;
        end
      end else if (byte_offset == OFS_TYPE) begin
        desc_type_next = data_byte;
      end else if (desc_type == TYPE_INTERFACE) begin
        case (byte_offset)
          OFS_IF_NUM:   tok.op = OP_IF_NUM;
          OFS_IF_CLASS: tok.op = OP_IF_CLASS;
          OFS_IF_SUB:   tok.op = OP_IF_SUB;
          OFS_IF_PROTO: tok.op = OP_IF_PROTO;
          default:      tok.op = OP_NONE;
        endcase
      end else if (desc_type == TYPE_ENDPOINT) begin
        case (byte_offset)
          OFS_EP_ADDR:   tok.op = OP_EP_ADDR;
          OFS_EP_ATTR:   tok.op = OP_EP_ATTR;
          OFS_EP_MPS_LO: tok.op = OP_EP_MPS_LO;
          OFS_EP_MPS_HI: tok.op = OP_EP_MPS_HI;
          default:       tok.op = OP_NONE;
        endcase
      end
      if (!halted_next) begin
        if (offset_inc >= {1'b0, desc_length_next}) begin
          byte_offset_next = 8'd0;
        end else begin
          byte_offset_next = offset_inc[7:0];
        end
      end
    end

    if (last_byte) begin
      byte_offset_next = 8'd0;
      desc_length_next = 8'd0;
      desc_type_next   = 8'd0;
      halted_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= 8'd0;
      desc_length <= 8'd0;
      desc_type   <= 8'd0;
      halted      <= 1'b0;
    end else if (beat) begin
      byte_offset <= byte_offset_next;
      desc_length <= desc_length_next;
      desc_type   <= desc_type_next;
      halted      <= halted_next;
    end
  end

endmodule

[hw/rtl/ucds_queue.sv]
// Short token queue between the front and back ends of the scanner.
// Depends on ucds_pkg for the token type.
module ucds_queue import ucds_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  input  logic   pop,
  output logic   tok_valid,
  output token_t pop_tok
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  token_t              slots [DEPTH];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full      = (count == CntW'(DEPTH));
  assign tok_valid = (count != '0);
  assign pop_tok   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/ucds_back.sv]
// Back end of the scanner: holds the match registers, applies tokens to the
// interface and endpoint state and registers the result. Depends on ucds_pkg.
module ucds_back import ucds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        tok_valid,
  input  token_t      tok,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic        malformed,
  output logic [7:0]  iface_num,
  output logic [3:0]  ep_num,
  output logic [15:0] max_packet
);

  logic [7:0]  want_class, want_subclass, want_protocol;

  prog_t       progress, progress_next;
  logic        iface_seen, iface_seen_next;
  logic [7:0]  iface_number, iface_number_next;
  logic [7:0]  pending_iface, pending_iface_next;
  logic [7:0]  ep_address, ep_address_next;
  logic [7:0]  ep_attributes, ep_attributes_next;
  logic [15:0] mps, mps_next;
  logic        ep_found, ep_found_next;
  logic        halted, halted_next;

  assign pop = tok_valid && (!tok.last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      want_class    <= CLASS_RESET;
      want_subclass <= SUBCLASS_RESET;
      want_protocol <= PROTOCOL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLASS:    want_class    <= cfg_data;
        REG_SUBCLASS: want_subclass <= cfg_data;
        REG_PROTOCOL: want_protocol <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_comb begin
    progress_next      = progress;
    iface_seen_next    = iface_seen;
    iface_number_next  = iface_number;
    pending_iface_next = pending_iface;
    ep_address_next    = ep_address;
    ep_attributes_next = ep_attributes;
    mps_next           = mps;
    ep_found_next      = ep_found;
    halted_next        = halted;

    if (!ep_found && !halted) begin
      case (tok.op)
        OP_ZERO_LEN: halted_next = 1'b1;
        OP_IF_NUM:   pending_iface_next = tok.data;
        OP_IF_CLASS: progress_next = (tok.data == want_class) ? PROG_CLASS : PROG_NONE;
        OP_IF_SUB: begin
          progress_next = (progress == PROG_CLASS && tok.data == want_subclass) ?
                          PROG_SUB : PROG_NONE;
        end
        OP_IF_PROTO: begin
          if (progress == PROG_SUB && tok.data == want_protocol) begin
            iface_seen_next   = 1'b1;
            iface_number_next = pending_iface;
          end
          progress_next = PROG_NONE;
        end
        OP_EP_ADDR: begin
          if (iface_seen) begin
            ep_address_next = tok.data;
          end
        end
        OP_EP_ATTR: begin
          if (iface_seen) begin
            ep_attributes_next = tok.data;
          end
        end
        OP_EP_MPS_LO: begin
          if (iface_seen) begin
            mps_next = {8'd0, tok.data};
          end
        end
        OP_EP_MPS_HI: begin
          if (iface_seen) begin
            mps_next = {tok.data, mps[7:0]};
            if (ep_attributes[1:0] == XFER_INTERRUPT && ep_address[EpDirBit]) begin
              ep_found_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      progress      <= PROG_NONE;
      iface_seen    <= 1'b0;
      iface_number  <= 8'd0;
      pending_iface <= 8'd0;
      ep_address    <= 8'd0;
      ep_attributes <= 8'd0;
      mps           <= 16'd0;
      ep_found      <= 1'b0;
      halted        <= 1'b0;
    end else if (pop) begin
      if (tok.last) begin
        progress      <= PROG_NONE;
        iface_seen    <= 1'b0;
        iface_number  <= 8'd0;
        pending_iface <= 8'd0;
        ep_address    <= 8'd0;
        ep_attributes <= 8'd0;
        mps           <= 16'd0;
        ep_found      <= 1'b0;
        halted        <= 1'b0;
      end else begin
        progress      <= progress_next;
        iface_seen    <= iface_seen_next;
        iface_number  <= iface_number_next;
        pending_iface <= pending_iface_next;
        ep_address    <= ep_address_next;
        ep_attributes <= ep_attributes_next;
        mps           <= mps_next;
        ep_found      <= ep_found_next;
        halted        <= halted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && tok.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      found      <= ep_found_next;
      malformed  <= halted_next;
      iface_num  <= ep_found_next ? iface_number_next : 8'd0;
      ep_num     <= ep_found_next ? ep_address_next[3:0] : 4'd0;
      max_packet <= ep_found_next ? mps_next : 16'd0;
    end
  end

endmodule

[hw/rtl/usb_config_descriptor_scanner_core.sv]
// Top level of the USB configuration descriptor scanner: front end, token
// queue and back end. Depends on ucds_pkg, ucds_front, ucds_queue, ucds_back.
//
// Descriptor set bytes enter on the in channel (data_byte, last_byte), one
// beat per byte. The front end tracks the descriptor offset and type and
// queues one token per byte; the back end matches interface class, subclass
// and protocol against the three configuration registers and captures the
// first interrupt IN endpoint after a match.
// Only the beat that carries last_byte produces a result on the out channel:
// found, malformed, iface_num, ep_num and max_packet, the last three zero
// when nothing was found. The result is registered after that beat's token
// leaves the queue and is held in an output register until out_ready takes
// it. The block accepts one byte every cycle while the queue is not full.
// When the receiver stalls, the back end holds the last token while the
// queue fills, after which in_ready falls. Reset empties the queue, clears
// the scan state and loads the registers with class 3, subclass 1 and
// protocol 1. The user must write the registers through cfg_wr_en, cfg_index
// and cfg_data only while no set is in progress; the block doesn't enforce it.
module usb_config_descriptor_scanner_core import ucds_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic        malformed,
  output logic [7:0]  iface_num,
  output logic [3:0]  ep_num,
  output logic [15:0] max_packet
);

  logic   beat;
  logic   full;
  logic   pop;
  logic   tok_valid;
  token_t front_tok;
  token_t back_tok;

  assign in_ready = !full;
  assign beat     = in_valid && in_ready;

  ucds_front u_front (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .tok       (front_tok)
  );

  ucds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (beat),
    .push_tok  (front_tok),
    .full      (full),
    .pop       (pop),
    .tok_valid (tok_valid),
    .pop_tok   (back_tok)
  );

  ucds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tok_valid  (tok_valid),
    .tok        (back_tok),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .malformed  (malformed),
    .iface_num  (iface_num),
    .ep_num     (ep_num),
    .max_packet (max_packet)
  );

endmodule

[dv/usb_config_descriptor_scanner_core_tb.sv]
// Self-checking testbench for usb_config_descriptor_scanner_core: descriptor sets go in a byte
// per beat under random bursts and stalls, and each result is checked against a scan predictor.
// Depends on ucds_pkg and the scanner core RTL only.
module usb_config_descriptor_scanner_core_tb;
  import ucds_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {ITEM_BYTE, ITEM_HOLD, ITEM_CFG} item_kind_e;
  typedef enum logic [1:0] {RX_STEADY, RX_CHOPPY, RX_SLOW} rx_mode_e;

  typedef struct {
    item_kind_e kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] idx;
  } stream_item_t;

  typedef struct {
    logic        found;
    logic        malformed;
    logic [7:0]  iface;
    logic [3:0]  ep;
    logic [15:0] mps;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_CLASS;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic        malformed;
  logic [7:0]  iface_num;
  logic [3:0]  ep_num;
  logic [15:0] max_packet;

  stream_item_t item_queue [$];
  scan_result_t scan_results [$];
  int unsigned  error_count = 0;
  int unsigned  idle_cycles = 0;

  // Scan predictor state and its copy of the match registers.
  logic [7:0]  cfg_class = CLASS_RESET;
  logic [7:0]  cfg_subclass = SUBCLASS_RESET;
  logic [7:0]  cfg_protocol = PROTOCOL_RESET;
  logic [7:0]  scan_ofs, scan_len, scan_type;
  prog_t       match_step;
  logic        iface_hit, ep_hit, halted;
  logic [7:0]  iface_cur, iface_pend, ep_addr, ep_attr;
  logic [15:0] ep_mps;

  usb_config_descriptor_scanner_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .malformed  (malformed),
    .iface_num  (iface_num),
    .ep_num     (ep_num),
    .max_packet (max_packet)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic clear_scan();
    scan_ofs = 8'h00; scan_len = 8'h00; scan_type = 8'h00;
    match_step = PROG_NONE;
    iface_hit = 1'b0; iface_cur = 8'h00; iface_pend = 8'h00;
    ep_addr = 8'h00; ep_attr = 8'h00; ep_mps = 16'h0000;
    ep_hit = 1'b0; halted = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    scan_result_t res;
    if (!ep_hit && !halted) begin
      if (scan_ofs == OFS_LENGTH && b == 8'h00) begin
        halted = 1'b1;
      end else begin
        if (scan_ofs == OFS_LENGTH) begin
          scan_len = b;
          scan_type = 8'h00;
          match_step = PROG_NONE;
        end else if (scan_ofs == OFS_TYPE) begin
          scan_type = b;
        end else if (scan_type == TYPE_INTERFACE) begin
          case (scan_ofs)
            OFS_IF_NUM: iface_pend = b;
            OFS_IF_CLASS: match_step = (b == cfg_class) ? PROG_CLASS : PROG_NONE;
            OFS_IF_SUB: begin
              match_step = (match_step == PROG_CLASS && b == cfg_subclass) ? PROG_SUB : PROG_NONE;
            end
            OFS_IF_PROTO: begin
              if (match_step == PROG_SUB && b == cfg_protocol) begin
                iface_hit = 1'b1;
                iface_cur = iface_pend;
              end
              match_step = PROG_NONE;
            end
            default: ;
          endcase
        end else if (scan_type == TYPE_ENDPOINT && iface_hit) begin
          case (scan_ofs)
            OFS_EP_ADDR: ep_addr = b;
            OFS_EP_ATTR: ep_attr = b;
            OFS_EP_MPS_LO: ep_mps = {8'h00, b};
            OFS_EP_MPS_HI: begin
              ep_mps = {b, ep_mps[7:0]};
              if (ep_attr[1:0] == XFER_INTERRUPT && ep_addr[EpDirBit]) ep_hit = 1'b1;
            end
            default: ;
          endcase
        end
        if ({1'b0, scan_ofs} + 9'd1 >= {1'b0, scan_len}) scan_ofs = 8'h00;
        else scan_ofs = scan_ofs + 8'd1;
      end
    end
    if (last) begin
      res.found = ep_hit;
      res.malformed = halted;
      res.iface = ep_hit ? iface_cur : 8'h00;
      res.ep = ep_hit ? ep_addr[3:0] : 4'h0;
      res.mps = ep_hit ? ep_mps : 16'h0000;
      scan_results.push_back(res);
      clear_scan();
    end
  endtask

  task automatic add_byte(input logic [7:0] d, input logic l);
    item_queue.push_back('{kind: ITEM_BYTE, data: d, last: l, idx: REG_CLASS});
  endtask

  task automatic add_cfg(input logic [1:0] i, input logic [7:0] v);
    item_queue.push_back('{kind: ITEM_CFG, data: v, last: 1'b0, idx: i});
  endtask

  // Mostly well-formed sets built from interface and endpoint descriptors with random content,
  // with short, truncated and zero length descriptors mixed in; one set in ten is pure noise.
  task automatic build_set(input logic [7:0] cls, input logic [7:0] sub, input logic [7:0] proto);
    logic [7:0] tpl [12];
    logic [7:0] body [$];
    int n_desc, len, pick, k, j;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 40);
      for (j = 0; j < len; j++) body.push_back(8'($urandom));
    end else begin
      n_desc = $urandom_range(1, 5);
      for (k = 0; k < n_desc; k++) begin
        for (j = 0; j < 12; j++) tpl[j] = 8'($urandom);
        pick = (k == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 9);
        if (pick < 4) begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 7) : $urandom_range(8, 12);
          tpl[1] = TYPE_INTERFACE;
          if ($urandom_range(0, 7) != 0) tpl[5] = cls;
          if ($urandom_range(0, 7) != 0) tpl[6] = sub;
          if ($urandom_range(0, 7) != 0) tpl[7] = proto;
        end else if (pick < 8) begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 5) : $urandom_range(6, 8);
          tpl[1] = TYPE_ENDPOINT;
          if ($urandom_range(0, 3) != 0) tpl[2][EpDirBit] = 1'b1;
          if ($urandom_range(0, 3) != 0) tpl[3][1:0] = XFER_INTERRUPT;
        end else if (pick == 8) begin
          len = $urandom_range(1, 12);
        end else begin
          len = 0;
        end
        tpl[0] = 8'(len);
        for (j = 0; j < ((len == 0) ? 1 : len); j++) body.push_back(tpl[j]);
      end
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(1, body.size());
        while (body.size() > len) void'(body.pop_back());
      end
    end
    for (j = 0; j < body.size(); j++) add_byte(body[j], j == body.size() - 1);
  endtask

  // Sender: bursts of beats with random gaps; hold and register items wait for an empty pipeline.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned settle = 0;

  always @(posedge clk) begin : drive
    stream_item_t it;
    logic       nv, nl, nwr;
    logic [7:0] nd, ncd;
    logic [1:0] ni;
    nv = in_valid; nd = data_byte; nl = last_byte;
    nwr = 1'b0; ni = cfg_index; ncd = cfg_data;
    if (rst) begin
      nv = 1'b0;
      cfg_class = CLASS_RESET;
      cfg_subclass = SUBCLASS_RESET;
      cfg_protocol = PROTOCOL_RESET;
      clear_scan();
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(data_byte, last_byte);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_queue.size() > 0) begin
          it = item_queue[0];
          if (it.kind == ITEM_BYTE) begin
            void'(item_queue.pop_front());
            nv = 1'b1;
            nd = it.data;
            nl = it.last;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 40);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
              burst_left--;
            end
          end else if (scan_results.size() != 0) begin
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            settle = 0;
            void'(item_queue.pop_front());
            if (it.kind == ITEM_CFG) begin
              nwr = 1'b1;
              ni = it.idx;
              ncd = it.data;
              case (it.idx)
                REG_CLASS: cfg_class = it.data;
                REG_SUBCLASS: cfg_subclass = it.data;
                REG_PROTOCOL: cfg_protocol = it.data;
                default: ;
              endcase
            end
          end
        end
      end
    end
    in_valid <= nv;
    data_byte <= nd;
    last_byte <= nl;
    cfg_wr_en <= nwr;
    cfg_index <= ni;
    cfg_data <= ncd;
  end

  // Receiver: stalls in randomly chosen modes, steady mode included.
  rx_mode_e    rx_mode = RX_STEADY;
  int unsigned mode_left = 0;

  always @(posedge clk) begin : observe
    scan_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (scan_results.size() == 0) begin
          report("result with no set pending", {15'h0, found}, 16'h0);
        end else begin
          want = scan_results.pop_front();
          if (found !== want.found) report("found", {15'h0, found}, {15'h0, want.found});
          if (malformed !== want.malformed) begin
            report("malformed", {15'h0, malformed}, {15'h0, want.malformed});
          end
          if (iface_num !== want.iface) report("iface_num", {8'h0, iface_num}, {8'h0, want.iface});
          if (ep_num !== want.ep) report("ep_num", {12'h0, ep_num}, {12'h0, want.ep});
          if (max_packet !== want.mps) report("max_packet", max_packet, want.mps);
        end
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] cls, sub, proto;
    int phase, sets, mark;
    // A matching keyboard interface and an interrupt IN endpoint with the largest packet size;
    // the zero length byte after the capture must not flag the set as malformed.
    add_byte(8'd9, 1'b0); add_byte(TYPE_INTERFACE, 1'b0); add_byte(8'h05, 1'b0);
    add_byte(8'h00, 1'b0); add_byte(8'h01, 1'b0); add_byte(CLASS_RESET, 1'b0);
    add_byte(SUBCLASS_RESET, 1'b0); add_byte(PROTOCOL_RESET, 1'b0); add_byte(8'h00, 1'b0);
    add_byte(8'd6, 1'b0); add_byte(TYPE_ENDPOINT, 1'b0); add_byte(8'h8F, 1'b0);
    add_byte(8'h03, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b1);
    // A set made of a single zero length byte, then two length one descriptors and one cut off by the end.
    add_byte(8'h00, 1'b1);
    add_byte(8'h01, 1'b0); add_byte(8'h01, 1'b0); add_byte(8'hFF, 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin cls = CLASS_RESET; sub = SUBCLASS_RESET; proto = PROTOCOL_RESET; end
        1: begin cls = 8'h00; sub = 8'h00; proto = 8'h00; end
        2: begin cls = 8'hFF; sub = 8'hFF; proto = 8'hFF; end
        default: begin cls = 8'($urandom); sub = 8'($urandom); proto = 8'($urandom); end
      endcase
      if (phase > 0) begin
        add_cfg(REG_CLASS, cls);
        add_cfg(REG_SUBCLASS, sub);
        add_cfg(REG_PROTOCOL, proto);
      end
      sets = 0;
      mark = item_queue.size();
      while (sets < 3 || item_queue.size() - mark < 70) begin
        if ((phase == 2 && sets == 2) || $urandom_range(0, 15) == 0) begin
          item_queue.push_back('{kind: ITEM_HOLD, data: 8'h00, last: 1'b0, idx: REG_CLASS});
        end
        build_set(cls, sub, proto);
        sets++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (item_queue.size() != 0 || in_valid || scan_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
